/* sv/ebp_pkg.sv */
`default_nettype none

package ebp_pkg;

    localparam int WORD_W  = 64;
    localparam int TICK_W  = 32;
    localparam int INDEX_W = 6;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd3000;

    localparam logic CAUSE_FULL    = 1'b0;
    localparam logic CAUSE_TIMEOUT = 1'b1;

    // Flush decision that travels with each stored event
    typedef struct packed {
        logic flush;
        logic cause;
    } t_flush_ctl;

endpackage

`default_nettype wire

/* sv/ebp_front.sv */
`default_nettype none

module ebp_front #(
    parameter int EVENTS_PER_PACKET = 20,
    parameter int COUNTER_BITS      = 55,
    parameter int SLOT_W            = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [ebp_pkg::WORD_W-1:0]  i_event_word0,
    input  wire logic [ebp_pkg::TICK_W-1:0]  i_now_ticks,
    input  wire logic                        i_cfg_valid,
    input  wire logic [ebp_pkg::TICK_W-1:0]  i_cfg_data,
    input  wire logic                        i_q_full,
    output logic                             o_q_push,
    output logic [SLOT_W-1:0]                o_q_slot,
    output ebp_pkg::t_flush_ctl              o_q_ctl
);

    logic [COUNTER_BITS-1:0]   r_last_counter;
    logic                      r_counter_seen;
    logic                      r_skip_pending;
    logic [SLOT_W-1:0]         r_event_count;
    logic [ebp_pkg::TICK_W-1:0] r_last_flush_time;
    logic [ebp_pkg::TICK_W-1:0] r_timeout_ticks;

    logic                       accept;
    logic [COUNTER_BITS-1:0]    counter;
    logic                       is_new;
    logic [SLOT_W:0]            next_count;
    logic                       pkt_full;
    logic [ebp_pkg::TICK_W-1:0] elapsed;
    logic                       timed_out;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign counter    = i_event_word0[COUNTER_BITS-1:0];
    assign is_new     = !r_counter_seen || (counter != r_last_counter);
    assign next_count = {1'b0, r_event_count} + (SLOT_W+1)'(1);
    assign pkt_full   = (next_count == (SLOT_W+1)'(EVENTS_PER_PACKET));
    // wraparound difference, compared unsigned
    assign elapsed    = i_now_ticks - r_last_flush_time;
    assign timed_out  = (elapsed >= r_timeout_ticks);

    assign o_q_push      = accept && is_new && !r_skip_pending;
    assign o_q_slot      = r_event_count;
    assign o_q_ctl.flush = pkt_full || timed_out;
    assign o_q_ctl.cause = pkt_full ? ebp_pkg::CAUSE_FULL : ebp_pkg::CAUSE_TIMEOUT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_counter    <= '0;
            r_counter_seen    <= 1'b0;
            r_skip_pending    <= 1'b1;
            r_event_count     <= '0;
            r_last_flush_time <= '0;
            r_timeout_ticks   <= ebp_pkg::TIMEOUT_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_timeout_ticks <= i_cfg_data;
            end
            if (accept && is_new) begin
                r_last_counter <= counter;
                r_counter_seen <= 1'b1;
                if (r_skip_pending) begin
                    // drop the first event after reset
                    r_skip_pending <= 1'b0;
                end else if (pkt_full || timed_out) begin
                    r_event_count <= '0;
                    if (!pkt_full) begin
                        r_last_flush_time <= i_now_ticks;
                    end
                end else begin
                    r_event_count <= next_count[SLOT_W-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

/* sv/ebp_queue.sv */
`default_nettype none

module ebp_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data,
    input  wire logic              i_pop
);

    logic [DATA_W-1:0] r_entry [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/ebp_back.sv */
`default_nettype none

module ebp_back #(
    parameter int EVENTS_PER_PACKET = 20,
    parameter int WORDS_PER_EVENT   = 3,
    parameter int SLOT_W            = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire logic [SLOT_W-1:0]             i_q_slot,
    input  wire ebp_pkg::t_flush_ctl           i_q_ctl,
    input  wire logic [ebp_pkg::WORD_W-1:0]    i_q_word0,
    input  wire logic [ebp_pkg::WORD_W-1:0]    i_q_word1,
    input  wire logic [ebp_pkg::WORD_W-1:0]    i_q_word2,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ebp_pkg::WORD_W-1:0]         o_out_word,
    output logic [ebp_pkg::INDEX_W-1:0]        o_word_index,
    output logic                               o_flush_cause,
    output logic                               o_last_word
);

    localparam int PACKET_WORDS = EVENTS_PER_PACKET * WORDS_PER_EVENT;
    localparam int IDX_W = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;
    localparam int CNT_W = $clog2(PACKET_WORDS + 1);
    localparam int SEL_W = (WORDS_PER_EVENT > 1) ? $clog2(WORDS_PER_EVENT) : 1;

    typedef enum logic [0:0] {
        S_WRITE,
        S_EMIT
    } t_state;

    t_state                     r_state;
    logic [SEL_W-1:0]           r_wsel;
    logic [CNT_W-1:0]           r_fill;
    logic                       r_cause;
    logic [IDX_W-1:0]           r_rd_idx;

    logic [ebp_pkg::WORD_W-1:0] r_mem [PACKET_WORDS];
    logic [ebp_pkg::WORD_W-1:0] r_rd_data;

    logic                       r_s1_valid;
    logic [IDX_W-1:0]           r_s1_idx;
    logic                       r_s1_pad;
    logic                       r_s1_cause;
    logic                       r_s1_last;

    logic                       r_out_valid;
    logic [ebp_pkg::WORD_W-1:0] r_out_word;
    logic [ebp_pkg::INDEX_W-1:0] r_word_index;
    logic                       r_flush_cause;
    logic                       r_last_word;

    logic                       wr_en;
    logic                       last_sel;
    logic [IDX_W-1:0]           wr_addr;
    logic [ebp_pkg::WORD_W-1:0] wr_data;
    logic                       out_free;
    logic                       s1_load;
    logic                       issue;

    assign wr_en    = (r_state == S_WRITE) && i_q_valid;
    assign last_sel = (4'(r_wsel) == 4'(WORDS_PER_EVENT - 1));
    assign wr_addr  = IDX_W'(i_q_slot * WORDS_PER_EVENT) + IDX_W'(r_wsel);
    assign o_q_pop  = wr_en && last_sel;

    // words beyond the third are stored as zero
    always_comb begin
        case (4'(r_wsel))
            4'd0:    wr_data = i_q_word0;
            4'd1:    wr_data = i_q_word1;
            4'd2:    wr_data = i_q_word2;
            default: wr_data = '0;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign s1_load  = !r_s1_valid || out_free;
    assign issue    = (r_state == S_EMIT) && s1_load;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WRITE;
            r_wsel      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_WRITE: begin
                    if (wr_en) begin
                        if (last_sel) begin
                            r_wsel <= '0;
                            if (i_q_ctl.flush) begin
                                r_state  <= S_EMIT;
                                r_fill   <= CNT_W'(wr_addr) + CNT_W'(1);
                                r_cause  <= i_q_ctl.cause;
                                r_rd_idx <= '0;
                            end
                        end else begin
                            r_wsel <= r_wsel + SEL_W'(1);
                        end
                    end
                end
                S_EMIT: begin
                    if (issue) begin
                        if (r_rd_idx == IDX_W'(PACKET_WORDS - 1)) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_rd_idx <= r_rd_idx + IDX_W'(1);
                        end
                    end
                end
                default: r_state <= S_WRITE;
            endcase

            if (s1_load) begin
                r_s1_valid <= issue;
                r_s1_idx   <= r_rd_idx;
                // zero the slots past the last stored event
                r_s1_pad   <= (CNT_W'(r_rd_idx) >= r_fill);
                r_s1_cause <= r_cause;
                r_s1_last  <= (r_rd_idx == IDX_W'(PACKET_WORDS - 1));
            end

            if (out_free) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_out_word    <= r_s1_pad ? '0 : r_rd_data;
                    r_word_index  <= ebp_pkg::INDEX_W'(r_s1_idx);
                    r_flush_cause <= r_s1_cause;
                    r_last_word   <= r_s1_last;
                end
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_word    = r_out_word;
    assign o_word_index  = r_word_index;
    assign o_flush_cause = r_flush_cause;
    assign o_last_word   = r_last_word;

endmodule

`default_nettype wire

/* sv/event_batch_packetizer_unit.sv */
`default_nettype none

// Event batch packetizer. Polled samples enter one per cycle while the queue
// is not full; a sample whose event counter (low COUNTER_BITS of word 0) is
// unchanged is consumed with no effect, and the first new event after reset
// is dropped. Each kept event takes one buffer-memory write per word in the
// back end, which pops the event only after its last word. A full packet
// (EVENTS_PER_PACKET events) or a timeout (timeout_ticks since the last
// timeout flush, modulo 2^32) emits EVENTS_PER_PACKET*WORDS_PER_EVENT words,
// one per cycle from the buffer read port while the receiver is ready, unused
// slots zeroed on a timeout; the back end takes no new event while a packet is
// read out. A two-entry queue lets the front keep taking samples meanwhile.
// No clearing pass is needed after reset. The timeout register may be written
// at any time while the block is idle; o_cfg_ready is always high.
module event_batch_packetizer_unit #(
    parameter int EVENTS_PER_PACKET = 20,
    parameter int WORDS_PER_EVENT   = 3,
    parameter int COUNTER_BITS      = 55
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [ebp_pkg::WORD_W-1:0]   i_event_word0,
    input  wire logic [ebp_pkg::WORD_W-1:0]   i_event_word1,
    input  wire logic [ebp_pkg::WORD_W-1:0]   i_event_word2,
    input  wire logic [ebp_pkg::TICK_W-1:0]   i_now_ticks,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [ebp_pkg::WORD_W-1:0]        o_out_word,
    output logic [ebp_pkg::INDEX_W-1:0]       o_word_index,
    output logic                              o_flush_cause,
    output logic                              o_last_word,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [ebp_pkg::TICK_W-1:0]   i_cfg_data
);

    localparam int PACKET_WORDS = EVENTS_PER_PACKET * WORDS_PER_EVENT;
    localparam int SLOT_W = (EVENTS_PER_PACKET > 1) ? $clog2(EVENTS_PER_PACKET) : 1;
    localparam int Q_W    = 2 + SLOT_W + 3 * ebp_pkg::WORD_W;
    localparam int WW     = ebp_pkg::WORD_W;

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    logic [SLOT_W-1:0]     push_slot;
    ebp_pkg::t_flush_ctl   push_ctl;
    logic [Q_W-1:0]        q_in;
    logic [Q_W-1:0]        q_out;
    logic [SLOT_W-1:0]     head_slot;
    ebp_pkg::t_flush_ctl   head_ctl;

    assign o_cfg_ready = 1'b1;

    ebp_front #(
        .EVENTS_PER_PACKET (EVENTS_PER_PACKET),
        .COUNTER_BITS      (COUNTER_BITS),
        .SLOT_W            (SLOT_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_event_word0 (i_event_word0),
        .i_now_ticks   (i_now_ticks),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_slot      (push_slot),
        .o_q_ctl       (push_ctl)
    );

    assign q_in = {push_ctl, push_slot, i_event_word2, i_event_word1, i_event_word0};

    ebp_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    assign head_ctl  = q_out[Q_W-1 -: 2];
    assign head_slot = q_out[3*WW +: SLOT_W];

    ebp_back #(
        .EVENTS_PER_PACKET (EVENTS_PER_PACKET),
        .WORDS_PER_EVENT   (WORDS_PER_EVENT),
        .SLOT_W            (SLOT_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_slot      (head_slot),
        .i_q_ctl       (head_ctl),
        .i_q_word0     (q_out[0 +: WW]),
        .i_q_word1     (q_out[WW +: WW]),
        .i_q_word2     (q_out[2*WW +: WW]),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word),
        .o_word_index  (o_word_index),
        .o_flush_cause (o_flush_cause),
        .o_last_word   (o_last_word)
    );

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_word)
            |-> (o_word_index == ebp_pkg::INDEX_W'(PACKET_WORDS - 1)))
        else $error("last word flagged at wrong index");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (!q_full || q_pop))
        else $error("queue pushed while full");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W      = ebp_pkg::WORD_W;
    localparam int TICK_W      = ebp_pkg::TICK_W;
    localparam int INDEX_W     = ebp_pkg::INDEX_W;

    localparam int EVENTS      = 20;
    localparam int WPE         = 3;
    localparam int CNT_BITS    = 55;
    localparam int PKT_WORDS   = EVENTS * WPE;
    localparam int LIMIT       = 4_000_000;
    localparam int SETTLE      = 32;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        logic               cause;
        logic               last;
    } t_pkt_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [WORD_W-1:0]   i_event_word0 = '0;
    logic [WORD_W-1:0]   i_event_word1 = '0;
    logic [WORD_W-1:0]   i_event_word2 = '0;
    logic [TICK_W-1:0]   i_now_ticks = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [WORD_W-1:0]   o_out_word;
    logic [INDEX_W-1:0]  o_word_index;
    logic                o_flush_cause;
    logic                o_last_word;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [TICK_W-1:0]   i_cfg_data = '0;

    // Predictor state
    logic [CNT_BITS-1:0] seen_counter = '0;
    logic                have_counter = 1'b0;
    logic                drop_next = 1'b1;
    int                  held_events = 0;
    logic [WORD_W-1:0]   slot_words [PKT_WORDS];
    logic [TICK_W-1:0]   flush_stamp = '0;
    logic [TICK_W-1:0]   timeout_limit = ebp_pkg::TIMEOUT_RESET;

    t_pkt_word           packet_words_due [$];
    t_pkt_word           due_word;
    int                  mismatch_cnt = 0;

    // Random traffic generator state
    logic [CNT_BITS-1:0] gen_counter = '0;
    logic [TICK_W-1:0]   gen_now = '0;

    logic [31:0]         cycle_cnt = '0;
    int                  ready_hold = 0;
    int                  ready_roll;
    wire                 quiet_span = (cycle_cnt[10:9] == 2'b11);

    event_batch_packetizer_unit #(
        .EVENTS_PER_PACKET (EVENTS),
        .WORDS_PER_EVENT   (WPE),
        .COUNTER_BITS      (CNT_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_event_word0 (i_event_word0),
        .i_event_word1 (i_event_word1),
        .i_event_word2 (i_event_word2),
        .i_now_ticks   (i_now_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word),
        .o_word_index  (o_word_index),
        .o_flush_cause (o_flush_cause),
        .o_last_word   (o_last_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycle_cnt,
                     packet_words_due.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiver stalls: mostly short, a few long, none begun during quiet spans
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= ready_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet_span) begin
                ready_roll = $urandom_range(0, 99);
                if (ready_roll < 12)
                    ready_hold <= $urandom_range(1, 3);
                else if (ready_roll < 14)
                    ready_hold <= $urandom_range(8, 50);
            end
        end
    end

    function automatic void note_mismatch(string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (packet_words_due.size() == 0) begin
                note_mismatch($sformatf("word %h idx %0d with nothing due",
                                        o_out_word, o_word_index));
            end else begin
                due_word = packet_words_due.pop_front();
                if (o_out_word !== due_word.word || o_word_index !== due_word.index ||
                    o_flush_cause !== due_word.cause || o_last_word !== due_word.last)
                    note_mismatch($sformatf(
                        "exp word %h idx %0d cause %b last %b, got %h idx %0d cause %b last %b",
                        due_word.word, due_word.index, due_word.cause, due_word.last,
                        o_out_word, o_word_index, o_flush_cause, o_last_word));
            end
        end
    end

    function automatic void queue_packet(logic cause);
        t_pkt_word w;
        for (int i = 0; i < PKT_WORDS; i++) begin
            w.word  = slot_words[i];
            w.index = INDEX_W'(i);
            w.cause = cause;
            w.last  = (i == PKT_WORDS - 1);
            packet_words_due.push_back(w);
        end
    endfunction

    function automatic void packetize_sample(logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                                             logic [WORD_W-1:0] w2, logic [TICK_W-1:0] now);
        logic [CNT_BITS-1:0] ctr;
        logic [TICK_W-1:0]   elapsed;
        int                  base;
        ctr = w0[CNT_BITS-1:0];
        if (have_counter && ctr == seen_counter)
            return;
        seen_counter = ctr;
        have_counter = 1'b1;
        // drop the first new event after reset
        if (drop_next) begin
            drop_next = 1'b0;
            return;
        end
        if (held_events >= EVENTS)
            held_events = 0;
        base = held_events * WPE;
        slot_words[base]     = w0;
        slot_words[base + 1] = w1;
        slot_words[base + 2] = w2;
        held_events++;
        if (held_events == EVENTS) begin
            held_events = 0;
            queue_packet(ebp_pkg::CAUSE_FULL);
        end else begin
            elapsed = now - flush_stamp;
            if (elapsed >= timeout_limit) begin
                for (int i = held_events * WPE; i < PKT_WORDS; i++)
                    slot_words[i] = '0;
                held_events = 0;
                flush_stamp = now;
                queue_packet(ebp_pkg::CAUSE_TIMEOUT);
            end
        end
    endfunction

    function automatic int unsigned sender_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet_span || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_sample(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                               input logic [WORD_W-1:0] w2, input logic [TICK_W-1:0] now);
        int unsigned gap;
        i_in_valid    <= 1'b1;
        i_event_word0 <= w0;
        i_event_word1 <= w1;
        i_event_word2 <= w2;
        i_now_ticks   <= now;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        packetize_sample(w0, w1, w2, now);
        gap = sender_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every due packet word has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (packet_words_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TICK_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        timeout_limit = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_first_event_drop();
        send_sample(64'h0, '1, 64'h0, 32'd0);
        // same counter, upper bits differ: no transaction effect
        send_sample(64'hFF80_0000_0000_0000, 64'h0, '1, 32'd0);
    endtask

    task automatic test_full_packet();
        logic [CNT_BITS-1:0] ctr;
        for (int k = 0; k < EVENTS; k++) begin
            ctr = (k == EVENTS - 1) ? '1 : CNT_BITS'(k + 1);
            send_sample({k[0] ? 9'h1FF : 9'h000, ctr},
                        k[0] ? '1 : '0,
                        k[0] ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA,
                        TICK_W'(k * 100));
        end
    endtask

    task automatic test_zero_timeout();
        write_timeout('0);
        send_sample(64'h0, 64'h0123_4567_89AB_CDEF, '1, '1);
    endtask

    // Elapsed time wraps: one tick short of the max timeout, then exactly on it
    task automatic test_max_timeout_wrap();
        write_timeout('1);
        send_sample(64'd5, 64'hDEAD_BEEF_0000_0001, 64'h8000_0000_0000_0000, 32'hFFFF_FFFD);
        send_sample(64'hFF80_0000_0000_0005, 64'h0, 64'h0, 32'hFFFF_FFFE);
        send_sample(64'd6, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1, 32'hFFFF_FFFE);
    endtask

    task automatic send_random_sample(output logic fresh);
        logic [WORD_W-1:0] w0;
        int unsigned       roll;
        roll  = $urandom_range(0, 99);
        fresh = 1'b1;
        if (roll < 55)
            gen_counter = gen_counter + CNT_BITS'($urandom_range(1, 3));
        else if (roll < 72)
            gen_counter = CNT_BITS'({$urandom, $urandom});
        else
            fresh = 1'b0;
        if ($urandom_range(0, 99) < 92)
            gen_now = gen_now + TICK_W'($urandom_range(0, 400));
        else
            gen_now = $urandom;
        w0 = {$urandom, $urandom};
        w0[CNT_BITS-1:0] = gen_counter;
        send_sample(w0, {$urandom, $urandom}, {$urandom, $urandom}, gen_now);
    endtask

    task automatic test_random_traffic(input logic [TICK_W-1:0] timeout, input int events);
        int   sent;
        logic fresh;
        sent = 0;
        write_timeout(timeout);
        while (sent < events) begin
            send_random_sample(fresh);
            if (fresh)
                sent++;
            if ($urandom_range(0, 99) < 3)
                wait_drained();
        end
    endtask

    initial begin
        for (int i = 0; i < PKT_WORDS; i++)
            slot_words[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_event_drop();
        test_full_packet();
        test_zero_timeout();
        test_max_timeout_wrap();

        test_random_traffic(ebp_pkg::TIMEOUT_RESET, 20);
        test_random_traffic(32'd60, 20);
        test_random_traffic(32'd1, 20);
        test_random_traffic(32'h8000_0000, 20);
        test_random_traffic('1, 20);
        test_random_traffic('0, 20);
        test_random_traffic(TICK_W'($urandom_range(100, 5000)), 20);

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (packet_words_due.size() != 0)
            $display("%0d packet words never arrived", packet_words_due.size());
        if (mismatch_cnt == 0 && packet_words_due.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
sv/ebp_pkg.sv
sv/ebp_front.sv
sv/ebp_queue.sv
sv/ebp_back.sv
sv/event_batch_packetizer_unit.sv
tb/sv/tb_top.sv
